// ===== rtl/kecl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kecl_pkg;

	localparam int KEYS = 16;

	// Configuration register indexes.
	localparam logic [7:0] REG_FIRST_CODE  = 8'd0;
	localparam logic [7:0] REG_SECOND_CODE = 8'd1;

	// Verdict codes.
	localparam logic [1:0] VERDICT_NONE    = 2'd0;
	localparam logic [1:0] VERDICT_WRONG   = 2'd1;
	localparam logic [1:0] VERDICT_CORRECT = 2'd2;

	// Reset values of the combination: '3' then '0'.
	localparam logic [7:0] FIRST_CODE_RESET  = 8'h33;
	localparam logic [7:0] SECOND_CODE_RESET = 8'h30;

	typedef struct packed {
		logic [15:0] scan_early;
		logic [15:0] scan_late;
	} in_word_t;

	typedef struct packed {
		logic       key_found;
		logic [7:0] key_char;
		logic [1:0] verdict;
	} out_word_t;

	typedef struct packed {
		logic [15:0] held_mask;
		logic        lock_phase;
	} lock_state_t;

	// Keypad layout, key index to ASCII: *0#D789C456B123A.
	function automatic logic [7:0] key_ascii(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:  ch = 8'h2A; // '*'
			4'd1:  ch = 8'h30; // '0'
			4'd2:  ch = 8'h23; // '#'
			4'd3:  ch = 8'h44; // 'D'
			4'd4:  ch = 8'h37;
			4'd5:  ch = 8'h38;
			4'd6:  ch = 8'h39;
			4'd7:  ch = 8'h43; // 'C'
			4'd8:  ch = 8'h34;
			4'd9:  ch = 8'h35;
			4'd10: ch = 8'h36;
			4'd11: ch = 8'h42; // 'B'
			4'd12: ch = 8'h31;
			4'd13: ch = 8'h32;
			4'd14: ch = 8'h33;
			4'd15: ch = 8'h41; // 'A'
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/kecl_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Debounce, edge detection, priority encode and lock decision for one word.
module kecl_eval (
	input  wire kecl_pkg::in_word_t    word,
	input  wire kecl_pkg::lock_state_t cur,
	input  wire logic [7:0]            first_code,
	input  wire logic [7:0]            second_code,
	output kecl_pkg::out_word_t        result,
	output kecl_pkg::lock_state_t      nxt
);
	import kecl_pkg::*;

	logic [15:0] deb;
	logic [15:0] fresh;
	logic [3:0]  idx;
	logic [7:0]  ch;

	assign deb   = word.scan_early & word.scan_late;
	assign fresh = deb & ~cur.held_mask;

	// Lowest set bit wins: scan from the top so the lowest overwrites last.
	always_comb begin
		idx = '0;
		for (int i = KEYS - 1; i >= 0; i--) begin
			if (fresh[i]) begin
				idx = 4'(i);
			end
		end
	end

	assign ch = key_ascii(idx);

	always_comb begin
		result.key_found = 1'b0;
		result.key_char  = '0;
		result.verdict   = VERDICT_NONE;
		nxt.held_mask    = deb;
		nxt.lock_phase   = cur.lock_phase;
		if (fresh != '0) begin
			result.key_found = 1'b1;
			result.key_char  = ch;
			if (!cur.lock_phase) begin
				result.verdict = (ch == first_code) ? VERDICT_NONE : VERDICT_WRONG;
				nxt.lock_phase = 1'b1;
			end else begin
				result.verdict = (ch == second_code) ? VERDICT_CORRECT : VERDICT_WRONG;
				nxt.lock_phase = 1'b0;
				// A key still held after the second key counts as new again.
				nxt.held_mask  = '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/keypad_edge_code_lock_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A scan word is accepted into the input register stage and its result word is
// then offered from the result register; out_stall can hold the word in between.
// Throughput: one scan word per cycle while not stalled; held mask and lock phase
// update in the same cycle that evaluates a word, so the next word follows at once.
// Reset (arst_n low, asynchronous): held mask and lock phase clear, the code
// registers return to '3' and '0', and both pipeline stages are emptied.
module keypad_edge_code_lock_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire kecl_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output kecl_pkg::out_word_t      out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_index,
	input  wire logic [7:0]          cfg_data
);
	import kecl_pkg::*;

	// Input register stage.
	logic        valid_s1;
	in_word_t    word_s1;

	// Persistent lock state and combination registers.
	lock_state_t state_q;
	logic [7:0]  first_code_q;
	logic [7:0]  second_code_q;

	// Result register.
	logic        out_valid_q;
	out_word_t   out_word_q;

	lock_state_t state_nxt;
	out_word_t   result;
	logic        advance;

	// The result register can take a new word when it is empty or being drained.
	// The input stage then moves forward, which frees it for the next scan word.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Configuration writes are to be made only while the block is idle; the block
	// itself does not enforce this, and the port is always ready.
	assign cfg_ready = 1'b1;

	kecl_eval u_eval (
		.word        (word_s1),
		.cur         (state_q),
		.first_code  (first_code_q),
		.second_code (second_code_q),
		.result      (result),
		.nxt         (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	// The lock state changes only when a word is evaluated and handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q  <= FIRST_CODE_RESET;
			second_code_q <= SECOND_CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			// Indexes beyond the two registers are dropped.
			if (cfg_index == REG_FIRST_CODE) begin
				first_code_q <= cfg_data;
			end
			if (cfg_index == REG_SECOND_CODE) begin
				second_code_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	// A verdict is only ever given for a detected key.
	a_verdict_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.verdict == VERDICT_NONE || out_word.key_found))
		else $error("verdict without a detected key");

	// No key, no character.
	a_char_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.key_found) |-> (out_word.key_char == 8'h00))
		else $error("key character without a detected key");

	// A key in the second phase ends the combination and clears the held mask.
	a_second_key_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && state_q.lock_phase && result.key_found)
		|=> (state_q.held_mask == '0 && !state_q.lock_phase))
		else $error("second key did not reset the lock");

	// Only the second key can complete the combination.
	a_correct_in_second_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result.verdict == VERDICT_CORRECT) |-> state_q.lock_phase)
		else $error("combination reported correct in the first phase");
`endif

endmodule

`default_nettype wire
